// ----- design/bsjc_pkg.sv -----
// Shared types and constants for the block shortcut jump chain.
// Used by the controller, the datapath and the top level; depends on nothing.
package bsjc_pkg;

   // Fixed field widths of the request, response and register
   localparam int POS_W = 10;
   localparam int LEN_W = 11;
   localparam int CNT_W = 11;

   // Active count after reset
   localparam logic [CNT_W-1:0] ACTIVE_RESET = 11'd1024;

   // Request command codes
   localparam logic CMD_SET   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic             command;
      logic [POS_W-1:0] position;
      logic [LEN_W-1:0] jump_length;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] last_position;
      logic [LEN_W-1:0] jump_count;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // latch the request beat
      logic clear_wr;   // write reset values at the sweep index
      logic all_start;  // arm a rebuild of every shortcut
      logic set_wr;     // store a jump length and arm a block rebuild
      logic rb_next;    // classify the entry whose jump length is read
      logic rb_write;   // write the shortcut of the current entry
      logic q_walk;     // follow one shortcut
      logic load_rsp;   // load the response register
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic cmd_query;
      logic in_table;
      logic in_live;
      logic j_zero;
      logic j_at_stop;
      logic walk_end;
      logic rebuild_pend;
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/bsjc_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; instanced by the datapath for the jump and shortcut tables.
module bsjc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word (old data on a same-address clash)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bsjc_ctrl.sv -----
// Controller state machine of the block shortcut jump chain.
// Depends on bsjc_pkg for the command and status structs.
module bsjc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bsjc_pkg::dp_status_type status,
   output bsjc_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b0000000001,
      S_IDLE     = 10'b0000000010,
      S_DISPATCH = 10'b0000000100,
      S_SET      = 10'b0000001000,
      S_RB_ISSUE = 10'b0000010000,
      S_RB_NEXT  = 10'b0000100000,
      S_RB_WRITE = 10'b0001000000,
      S_Q_ISSUE  = 10'b0010000000,
      S_Q_WALK   = 10'b0100000000,
      S_Q_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Take a beat only when idle with no rebuild waiting
   assign req_stall = (state_ff != S_IDLE) || status.rebuild_pend;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.j_zero) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (status.rebuild_pend) begin
               cmd.all_start = 1'b1;
               state_in      = S_RB_ISSUE;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.cmd_query) begin
               state_in = status.in_live ? S_Q_ISSUE : S_Q_DONE;
            end else begin
               state_in = status.in_table ? S_SET : S_IDLE;
            end
         end
         S_SET: begin
            cmd.set_wr = 1'b1;
            state_in   = S_RB_ISSUE;
         end
         S_RB_ISSUE: begin
            state_in = S_RB_NEXT;
         end
         S_RB_NEXT: begin
            cmd.rb_next = 1'b1;
            state_in    = S_RB_WRITE;
         end
         S_RB_WRITE: begin
            cmd.rb_write = 1'b1;
            state_in     = status.j_at_stop ? S_IDLE : S_RB_NEXT;
         end
         S_Q_ISSUE: begin
            state_in = S_Q_WALK;
         end
         S_Q_WALK: begin
            cmd.q_walk = 1'b1;
            if (status.walk_end) begin
               state_in = S_Q_DONE;
            end
         end
         S_Q_DONE: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Start with a clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/bsjc_dpath.sv -----
// Datapath of the block shortcut jump chain: register, tables, rebuild and walk.
// Depends on bsjc_pkg and instances bsjc_ram for the jump and shortcut tables.
module bsjc_dpath #(
   parameter int NUM_POSITIONS = 1024,
   parameter int BLOCK_SIZE    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bsjc_pkg::ctrl_cmd_type          cmd,
   output bsjc_pkg::dp_status_type         status,
   input  bsjc_pkg::req_type               req_data,
   input  logic                            csr_we,
   input  logic [bsjc_pkg::CNT_W-1:0]      csr_wdata,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output bsjc_pkg::rsp_type               rsp_data
);

   localparam int PW  = $clog2(NUM_POSITIONS);
   localparam int NW  = $clog2(NUM_POSITIONS + 1);
   localparam int JW  = (NW > bsjc_pkg::LEN_W) ? NW : bsjc_pkg::LEN_W;
   localparam int SW  = JW + 1;
   localparam int HW  = $clog2(BLOCK_SIZE + 1);
   localparam int LB  = $clog2(BLOCK_SIZE);
   localparam int TW  = bsjc_pkg::LEN_W;
   localparam int SCW = HW + PW;

   localparam logic [SW-1:0] N_S        = SW'(NUM_POSITIONS);
   localparam logic [SW-1:0] BS_S       = SW'(BLOCK_SIZE);
   localparam logic [JW-1:0] JUMP_RESET = JW'(NUM_POSITIONS);
   localparam logic [PW-1:0] LAST_IDX   = PW'(NUM_POSITIONS - 1);

   // Registers
   logic [bsjc_pkg::CNT_W-1:0] active_count_ff, active_count_in;
   logic                       pend_ff, pend_in;
   logic                       op_ff, op_in;
   logic [TW-1:0]              len_ff, len_in;
   logic [SW-1:0]              pos_ff, pos_in;
   logic [TW-1:0]              total_ff, total_in;
   logic [PW-1:0]              j_ff, j_in;
   logic [PW-1:0]              stop_ff, stop_in;
   logic                       exit_ff, exit_in;
   logic                       leave_ff, leave_in;
   logic [PW-1:0]              nxt_ff, nxt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bsjc_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   // Table ports
   logic          jump_wr_en;
   logic [PW-1:0] jump_wr_addr;
   logic [JW-1:0] jump_wr_data;
   logic [PW-1:0] jump_rd_addr;
   logic [JW-1:0] jump_rd_data;
   logic          sc_wr_en;
   logic [SCW-1:0] sc_wr_data;
   logic [PW-1:0] sc_rd_addr;
   logic [SCW-1:0] sc_rd_data;

   // Working values
   logic [SW-1:0] live_s;
   logic [SW-1:0] active_s;
   logic [SW-1:0] j_s;
   logic [SW-1:0] nxt_s;
   logic [SW-1:0] blk_start_s;
   logic [SW-1:0] blk_end_s;
   logic [SW-1:0] blk_last_s;
   logic [SW-1:0] hops_s;
   logic [HW-1:0] sc_hops;
   logic [PW-1:0] sc_target;
   logic [TW-1:0] len_fix;
   logic          walk_end;
   logic          walk_step;

   // Count in effect is the register clipped to the table size
   assign active_s = SW'(active_count_ff);
   assign live_s   = (active_s > N_S) ? N_S : active_s;

   // Split the shortcut word
   assign sc_hops   = sc_rd_data[SCW-1:PW];
   assign sc_target = sc_rd_data[PW-1:0];
   assign hops_s    = SW'(sc_hops);

   // Follow a shortcut until it points back at its own entry
   assign walk_end  = (SW'(sc_target) == pos_ff);
   assign walk_step = cmd.q_walk && !walk_end;

   // Block bounds of the position being set
   assign blk_start_s = (pos_ff >> LB) << LB;
   assign blk_end_s   = blk_start_s + BS_S;
   assign blk_last_s  = ((blk_end_s > N_S) ? N_S : blk_end_s) - SW'(1);

   // Landing position of the entry under rebuild
   assign j_s   = SW'(j_ff);
   assign nxt_s = j_s + SW'(jump_rd_data);

   // A zero jump length is stored as one
   assign len_fix = (len_ff == '0) ? TW'(1) : len_ff;

   // Jump table port selection
   always_comb begin
      jump_wr_en   = cmd.clear_wr || cmd.set_wr;
      jump_wr_addr = cmd.clear_wr ? j_ff : pos_ff[PW-1:0];
      jump_wr_data = cmd.clear_wr ? JUMP_RESET : JW'(len_fix);
      // read ahead the next lower entry while writing the current one
      jump_rd_addr = cmd.rb_write ? (j_ff - PW'(1)) : j_ff;
   end

   // Shortcut table port selection
   always_comb begin
      sc_wr_en = cmd.clear_wr || cmd.rb_write;
      if (cmd.clear_wr || exit_ff) begin
         sc_wr_data = {HW'(0), j_ff};
      end else if (leave_ff) begin
         sc_wr_data = {HW'(1), nxt_ff};
      end else begin
         sc_wr_data = {sc_hops + HW'(1), sc_target};
      end
      if (cmd.rb_next) begin
         sc_rd_addr = nxt_s[PW-1:0];
      end else if (cmd.q_walk) begin
         sc_rd_addr = sc_target;
      end else begin
         sc_rd_addr = pos_ff[PW-1:0];
      end
   end

   bsjc_ram #(
      .WIDTH (JW),
      .DEPTH (NUM_POSITIONS)
   ) u_jump_ram (
      .clock   (clock),
      .wr_en   (jump_wr_en),
      .wr_addr (jump_wr_addr),
      .wr_data (jump_wr_data),
      .rd_addr (jump_rd_addr),
      .rd_data (jump_rd_data)
   );

   bsjc_ram #(
      .WIDTH (SCW),
      .DEPTH (NUM_POSITIONS)
   ) u_shortcut_ram (
      .clock   (clock),
      .wr_en   (sc_wr_en),
      .wr_addr (j_ff),
      .wr_data (sc_wr_data),
      .rd_addr (sc_rd_addr),
      .rd_data (sc_rd_data)
   );

   // Register write arms a full rebuild
   always_comb begin
      active_count_in = csr_we ? csr_wdata : active_count_ff;
      pend_in         = csr_we || (pend_ff && !cmd.all_start);
   end

   // Latch the request beat, then advance the walk
   always_comb begin
      op_in    = cmd.accept ? req_data.command : op_ff;
      len_in   = cmd.accept ? req_data.jump_length : len_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      if (cmd.accept) begin
         pos_in   = SW'(req_data.position);
         total_in = '0;
      end else if (walk_step) begin
         pos_in   = SW'(sc_target);
         total_in = total_ff + hops_s[TW-1:0];
      end
   end

   // Sweep index and the lowest entry of the pass
   always_comb begin
      j_in    = j_ff;
      stop_in = stop_ff;
      if (cmd.all_start) begin
         j_in    = LAST_IDX;
         stop_in = '0;
      end else if (cmd.set_wr) begin
         j_in    = blk_last_s[PW-1:0];
         stop_in = blk_start_s[PW-1:0];
      end else if (cmd.clear_wr || (cmd.rb_write && (j_ff != stop_ff))) begin
         j_in = j_ff - PW'(1);
      end
   end

   // Classify the entry: leaves the range, leaves the block, or chains on
   always_comb begin
      exit_in  = exit_ff;
      leave_in = leave_ff;
      nxt_in   = nxt_ff;
      if (cmd.rb_next) begin
         exit_in  = (j_s >= live_s) || (nxt_s >= live_s);
         leave_in = (nxt_s >> LB) != (j_s >> LB);
         nxt_in   = nxt_s[PW-1:0];
      end
   end

   // Response register: load when free, drop once taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.last_position = pos_ff[bsjc_pkg::POS_W-1:0];
         rsp_data_in.jump_count    = total_ff + TW'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= bsjc_pkg::ACTIVE_RESET;
         pend_ff         <= 1'b0;
         j_ff            <= LAST_IDX;
         rsp_valid_ff    <= 1'b0;
      end else begin
         active_count_ff <= active_count_in;
         pend_ff         <= pend_in;
         j_ff            <= j_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      len_ff      <= len_in;
      pos_ff      <= pos_in;
      total_ff    <= total_in;
      stop_ff     <= stop_in;
      exit_ff     <= exit_in;
      leave_ff    <= leave_in;
      nxt_ff      <= nxt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Status to the controller
   always_comb begin
      status.cmd_query    = (op_ff == bsjc_pkg::CMD_QUERY);
      status.in_table     = (pos_ff < N_S);
      status.in_live      = (pos_ff < live_s);
      status.j_zero       = (j_ff == '0);
      status.j_at_stop    = (j_ff == stop_ff);
      status.walk_end     = walk_end;
      status.rebuild_pend = pend_ff;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/block_shortcut_jump_chain.sv -----
// Top level of the block shortcut jump chain: controller plus datapath.
// Depends on bsjc_pkg, bsjc_ctrl, bsjc_dpath and bsjc_ram.
//
// Keeps a jump length and a shortcut (hops to leave the block, landing
// position) for each of NUM_POSITIONS positions, in blocks of BLOCK_SIZE
// (a power of two). One item is worked at a time. After reset a clearing
// pass over every position runs with req_stall high. A set rebuilds its
// block from its end back to its start; for each entry the jump table is
// read, then the shortcut of the landing position. A set of a position
// outside the table is dropped. A query follows shortcuts, at most one per
// block; each hop is one shortcut table read. A query from a position
// outside the active range follows no shortcut. A query whose previous
// result still waits holds in its last cycle until that result is taken.
// A write of csr_wdata rebuilds every shortcut, during which no beat is
// taken. The response sits in an output register, so a new request is taken
// while a result waits.
module block_shortcut_jump_chain #(
   parameter int NUM_POSITIONS = 1024,
   parameter int BLOCK_SIZE    = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bsjc_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bsjc_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [bsjc_pkg::CNT_W-1:0] csr_wdata
);

   bsjc_pkg::ctrl_cmd_type  ctrl_cmd;
   bsjc_pkg::dp_status_type dp_status;

   bsjc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   bsjc_dpath #(
      .NUM_POSITIONS (NUM_POSITIONS),
      .BLOCK_SIZE    (BLOCK_SIZE)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // A result beat appears only after the controller loaded it
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl_cmd.load_rsp))
      else $error("response valid without a load");

   // Never overwrite a result that is still waiting
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_rsp |-> dp_status.out_free)
      else $error("response register overwritten");

   // No request beat while a full rebuild is owed
   a_no_beat_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !dp_status.rebuild_pend)
      else $error("beat taken with rebuild pending");

   // Datapath commands are mutually exclusive
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctrl_cmd))
      else $error("overlapping datapath commands");
`endif

endmodule
